>>> sv/binary_to_ascii_digits_top_macros.svh
// ----------------------------------------------------------------------------
// binary_to_ascii_digits_top_macros.svh - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ASCII_DIGITS_TOP_MACROS_SVH
`define BINARY_TO_ASCII_DIGITS_TOP_MACROS_SVH

// same-cycle implication
`define B2A_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg - shared types and constants
// Command/status structs and digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b2a_pkg;

    localparam int VALUE_PORT_W = 64;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 7;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
    localparam logic [DIGIT_W-1:0] DEC_RADIX  = 4'd10;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } b2a_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic cnt_zero;
    } b2a_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_RADIX)
        begin
            c = ASCII_ZERO + {3'b000, d};
        end
        else
        begin
            c = ASCII_A + {3'b000, d - DEC_RADIX};
        end
        return c;
    endfunction

endpackage

>>> sv/b2a_ctrl.sv
// ----------------------------------------------------------------------------
// b2a_ctrl - conversion sequencer
// Load, double-dabble steps, leading-zero skip and digit emission.
// ----------------------------------------------------------------------------
module b2a_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               hex_mode,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  b2a_pkg::b2a_stat_t stat,
    output b2a_pkg::b2a_cmd_t  cmd
);
    import b2a_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = hex_mode ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (stat.conv_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (stat.top_zero && !stat.cnt_zero)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift = 1'b1;
                    if (stat.cnt_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/b2a_dp.sv
// ----------------------------------------------------------------------------
// b2a_dp - conversion datapath
// Shift/add-3 BCD register, bit and digit counters, ASCII output.
// ----------------------------------------------------------------------------
module b2a_dp #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [b2a_pkg::VALUE_PORT_W-1:0]    value,
    input  logic                                hex_mode,
    input  b2a_pkg::b2a_cmd_t                   cmd,
    output b2a_pkg::b2a_stat_t                  stat,
    output logic [b2a_pkg::CHAR_W-1:0]          character,
    output logic                                last
);
    import b2a_pkg::*;

    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int DCW   = $clog2(NDIG);
    localparam int BCW   = $clog2(VALUE_WIDTH);

    localparam logic [DCW-1:0] DIG_LAST = DCW'(NDIG - 1);
    localparam logic [BCW-1:0] BIT_LAST = BCW'(VALUE_WIDTH - 1);

    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [DCW-1:0]         dig_cnt_reg, dig_cnt_next;
    logic [BCW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [DIGIT_W-1:0]     top_digit;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        bcd_next     = bcd_reg;
        bin_next     = bin_reg;
        dig_cnt_next = dig_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        if (cmd.load)
        begin
            dig_cnt_next = DIG_LAST;
            bit_cnt_next = BIT_LAST;
            bin_next     = value[VALUE_WIDTH-1:0];
            if (hex_mode)
            begin
                bcd_next = {{(BCD_W-VALUE_WIDTH){1'b0}}, value[VALUE_WIDTH-1:0]};
            end
            else
            begin
                bcd_next = '0;
            end
        end
        else if (cmd.conv)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next     = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end
        else if (cmd.shift)
        begin
            bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_cnt_reg <= '0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            dig_cnt_reg <= dig_cnt_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign top_digit      = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign stat.conv_last = (bit_cnt_reg == '0);
    assign stat.top_zero  = (top_digit == '0);
    assign stat.cnt_zero  = (dig_cnt_reg == '0);
    assign character      = digit_to_ascii(top_digit);
    assign last           = (dig_cnt_reg == '0);

endmodule

>>> sv/binary_to_ascii_digits_top.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_digits_top - binary to decimal/hex ASCII converter
// Emits the digits of one value per input transaction, MSD first.
//
//   channel | signals                     | payload
//   --------+-----------------------------+---------------------
//   in      | in_valid / in_ready         | value, hex_mode
//   out     | out_valid / out_ready       | character, last
//
// Decimal: after the accept, VALUE_WIDTH shift/add-3 steps run in the BCD step loop.
// Skip: leading zero digits are shifted out, one per step, then ST_SKIP exits; digits
// are then emitted one per cycle while out_ready is high; a low out_ready stalls them.
// Hex bypasses the BCD loop.
// One item in flight; in_ready is low until the last digit transaction.
// Reset clears the FSM state and the bit and digit counters only; out_ready stalls hold the digit.
// ----------------------------------------------------------------------------
`include "binary_to_ascii_digits_top_macros.svh"

module binary_to_ascii_digits_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [b2a_pkg::VALUE_PORT_W-1:0]  value,
    input  logic                              hex_mode,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [b2a_pkg::CHAR_W-1:0]        character,
    output logic                              last
);
    import b2a_pkg::*;

    b2a_cmd_t  cmd;
    b2a_stat_t stat;

    b2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .hex_mode  (hex_mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    b2a_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .hex_mode  (hex_mode),
        .cmd       (cmd),
        .stat      (stat),
        .character (character),
        .last      (last)
    );

    `B2A_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken during emit")
    `B2A_ASSERT_NEXT(a_conv_first, clk, rst_n, in_valid && in_ready, !out_valid, "digit before conversion")
    `B2A_ASSERT_NEXT(a_digits_burst, clk, rst_n, out_valid && out_ready && !last, out_valid, "gap within digits")
    `B2A_ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid && out_ready && last, in_ready, "not idle after last")

endmodule

>>> bench/tb_binary_to_ascii_digits_top.sv
// ----------------------------------------------------------------------------
// tb_binary_to_ascii_digits_top - self-checking bench for the ASCII digit converter
// Drives values in decimal and hex mode through the valid/ready input with
// bursty traffic, stalls the digit output on a changing pattern, and checks
// every digit transaction against a model of the expected character stream.
// ----------------------------------------------------------------------------
module tb_binary_to_ascii_digits_top;
    import b2a_pkg::*;

    localparam int VALUE_WIDTH  = 64;
    localparam int NUM_RANDOM   = 200;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_DIGITS   = 20;

    localparam logic [VALUE_PORT_W-1:0] VALUE_MASK =
        (VALUE_WIDTH >= VALUE_PORT_W) ? {VALUE_PORT_W{1'b1}}
                                      : ((64'd1 << VALUE_WIDTH) - 64'd1);

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } digit_t;

    class digit_scoreboard;
        digit_t expected_digits[$];
        int     errors;
        int     values_dec;
        int     values_hex;
        int     digits_checked;

        function new();
            errors         = 0;
            values_dec     = 0;
            values_hex     = 0;
            digits_checked = 0;
        endfunction

        function void note_value(logic [VALUE_PORT_W-1:0] v, logic hex);
            logic [VALUE_PORT_W-1:0] n;
            logic [VALUE_PORT_W-1:0] radix;
            logic [VALUE_PORT_W-1:0] d;
            logic [CHAR_W-1:0]       digs[MAX_DIGITS];
            int                      count;
            int                      k;
            digit_t                  item;
            n     = v & VALUE_MASK;
            radix = hex ? 64'd16 : 64'd10;
            count = 0;
            if (hex)
                values_hex++;
            else
                values_dec++;
            if (n == 0)
            begin
                digs[0] = ASCII_ZERO;
                count   = 1;
            end
            else
            begin
                while (n != 0 && count < MAX_DIGITS)
                begin
                    d = n % radix;
                    if (d > 9)
                        digs[count] = ASCII_A + CHAR_W'(d - 10);
                    else
                        digs[count] = ASCII_ZERO + CHAR_W'(d);
                    count++;
                    n = n / radix;
                end
            end
            for (k = count - 1; k >= 0; k--)
            begin
                item.character = digs[k];
                item.last      = (k == 0);
                expected_digits.push_back(item);
            end
        endfunction

        function void check_digit(logic [CHAR_W-1:0] character, logic last);
            digit_t exp_d;
            if (expected_digits.size() == 0)
            begin
                $display("%0t: unexpected digit transaction: character=%h last=%b",
                         $time, character, last);
                errors++;
            end
            else
            begin
                exp_d = expected_digits.pop_front();
                digits_checked++;
                if (character !== exp_d.character)
                begin
                    $display("%0t: character mismatch: expected %h actual %h",
                             $time, exp_d.character, character);
                    errors++;
                end
                if (last !== exp_d.last)
                begin
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, exp_d.last, last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [VALUE_PORT_W-1:0] value     = '0;
    logic                    hex_mode  = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [CHAR_W-1:0]       character;
    logic                    last;

    digit_scoreboard sb = new();
    int  burst_left   = 0;
    bit  hold_pending = 1'b0;
    int  cycle_count  = 0;

    binary_to_ascii_digits_top #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .hex_mode  (hex_mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_digit(character, last);
    end

    // receiver: phases of always-ready, random, sparse and periodic stalls
    initial
    begin
        int phase;
        int len;
        int hold_left;
        int i;
        hold_left = 0;
        forever
        begin
            phase = $urandom_range(0, 3);
            len   = $urandom_range(20, 200);
            for (i = 0; i < len; i++)
            begin
                @(posedge clk);
                if (hold_pending)
                begin
                    hold_pending = 1'b0;
                    hold_left    = HOLD_CYCLES;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    case (phase)
                        0: out_ready <= 1'b1;
                        1: out_ready <= ($urandom_range(0, 99) < 75);
                        2: out_ready <= ($urandom_range(0, 99) < 25);
                        default: out_ready <= (i % 3 == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d digits outstanding",
                 cycle_count, sb.pending());
        $display("FAIL");
        $finish;
    end

    task automatic offer(input logic [VALUE_PORT_W-1:0] v, input logic h);
        int gap;
        in_valid <= 1'b1;
        value    <= v;
        hex_mode <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_value(v, h);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 7);
        end
    endtask

    task automatic wait_all_digits();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    function automatic logic [VALUE_PORT_W-1:0] random_value();
        logic [VALUE_PORT_W-1:0] v;
        int                      k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 255));
            2: v = {$urandom, $urandom} >> k;
            3:
            begin
                v = 64'd1;
                repeat ($urandom_range(0, 19)) v = v * 64'd10;
                case ($urandom_range(0, 2))
                    0: v = v - 64'd1;
                    1: v = v + 64'd1;
                    default: ;
                endcase
            end
            4: v = {VALUE_PORT_W{1'b1}} >> k;
            default: v = 64'd1 << k;
        endcase
        return v;
    endfunction

    initial
    begin
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(64'd0, 1'b0);
        offer(64'd0, 1'b1);
        offer(64'd1, 1'b0);
        offer(64'd9, 1'b0);
        offer(64'd10, 1'b0);
        offer(64'd10, 1'b1);
        offer(64'd15, 1'b1);
        offer(64'd16, 1'b1);
        offer(64'd100, 1'b0);
        offer(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        offer(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        offer(64'd10000000000000000000, 1'b0);
        offer(64'd9999999999999999999, 1'b0);
        offer(64'h8000_0000_0000_0000, 1'b0);
        offer(64'h8000_0000_0000_0000, 1'b1);
        offer(64'h0123_4567_89AB_CDEF, 1'b1);
        offer(64'hFEDC_BA98_7654_3210, 1'b1);
        offer(64'hFEDC_BA98_7654_3210, 1'b0);
        offer(64'h5555_5555_5555_5555, 1'b0);
        offer(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        offer(64'd1234567890, 1'b0);
        wait_all_digits();

        for (i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 4)
                hold_pending = 1'b1;
            if (i == NUM_RANDOM / 2)
                wait_all_digits();
            offer(random_value(), 1'($urandom_range(0, 1)));
        end
        wait_all_digits();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d values (%0d decimal, %0d hex), %0d digits checked",
                 sb.values_dec + sb.values_hex, sb.values_dec, sb.values_hex,
                 sb.digits_checked);
        $display("errors: %0d", sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
